// ===== src/bddq_pkg.sv =====
`timescale 1ns / 1ps

package bddq_pkg;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_DELETE     = 2'd2,
        MODE_DUMP       = 2'd3
    } mode_t;

    // Status codes returned with every result item.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } state_t;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned LENGTH_W = 8;

endpackage

// ===== src/bounded_deque_with_positional_delete.sv =====
`timescale 1ns / 1ps
// Pushes, dumps of an empty list and every request that fails or hits the end of the list
// give their one result in the output register at the edge after acceptance; a new item is
// taken once IDLE again. A delete at position p of n elements moves the n-p elements behind
// it down one slot; each needs one read and one write of the single-port-per-direction element
// memory. A dump reads each element via the registered memory read and can stall on the output.
// Reset (rst_n low, asynchronous) empties the list; element storage is not cleared.

module bounded_deque_with_positional_delete
    import bddq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] value, [39:32] position
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] item_value, [39:32] list_length
    output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] has_item
    output logic        m_axis_tlast
);

    localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = PW + 1;
    localparam int unsigned IW = CW + 1;

    // Control state.
    state_t          state_reg, state_next;
    logic [PW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [PW-1:0]   idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;

    // Output payload.
    status_t             status_reg, status_next;
    logic                has_item_reg, has_item_next;
    logic [VALUE_W-1:0]  item_reg, item_next;
    logic [LENGTH_W-1:0] length_reg, length_next;
    logic                last_reg, last_next;

    // Element memory, stored as a ring starting at head_reg.
    logic [VALUE_W-1:0]  mem [CAPACITY];
    logic [VALUE_W-1:0]  rd_data_reg;
    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    logic [VALUE_W-1:0]  wr_data;

    // Shared address unit: physical slot of logical offset from head.
    logic [CW-1:0]       addr_off;
    logic [AW-1:0]       addr_sum;
    logic [PW-1:0]       phys_addr;
    logic [PW-1:0]       head_dec;

    // Input decode.
    mode_t               in_mode;
    logic [VALUE_W-1:0]  in_value;
    logic [7:0]          in_pos;
    logic                in_ready;
    logic                out_free;
    logic                full;
    logic [IW-1:0]       idx_ext;

    assign in_mode  = mode_t'(s_axis_tuser);
    assign in_value = s_axis_tdata[31:0];
    assign in_pos   = s_axis_tdata[39:32];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign full     = (count_reg == CW'(CAPACITY));
    assign idx_ext  = IW'(idx_reg);

    assign addr_sum  = AW'(head_reg) + AW'(addr_off);
    assign phys_addr = (addr_sum >= AW'(CAPACITY)) ? PW'(addr_sum - AW'(CAPACITY))
                                                   : PW'(addr_sum);
    assign head_dec  = (head_reg == '0) ? PW'(CAPACITY - 1) : head_reg - PW'(1);

    // Offset select for the address unit.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   addr_off = count_reg;
            ST_DEL_RD: addr_off = CW'(idx_ext + IW'(1));
            default:   addr_off = CW'(idx_reg);
        endcase
    end

    // Sequencer: next state, memory write and result loading.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        has_item_next  = has_item_reg;
        item_next      = item_reg;
        length_next    = length_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = phys_addr;
        wr_data        = in_value;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && in_ready)
                begin
                    // Default result: single status item, no element.
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    has_item_next  = 1'b0;
                    item_next      = '0;
                    length_next    = LENGTH_W'(count_reg);
                    last_next      = 1'b1;
                    unique case (in_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (in_mode == MODE_PUSH_FRONT)
                                begin
                                    wr_addr   = head_dec;
                                    head_next = head_dec;
                                end
                                count_next  = count_reg + CW'(1);
                                length_next = LENGTH_W'(count_reg + CW'(1));
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else if (in_pos == 8'd0 || in_pos > 8'(count_reg))
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else if (in_pos < 8'(count_reg))
                            begin
                                // Elements behind the hole must move down one slot.
                                out_valid_next = 1'b0;
                                idx_next       = PW'(in_pos - 8'd1);
                                state_next     = ST_DEL_RD;
                            end
                            else
                            begin
                                count_next  = count_reg - CW'(1);
                                length_next = LENGTH_W'(count_reg - CW'(1));
                            end
                        end
                        MODE_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                idx_next       = '0;
                                state_next     = ST_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_DEL_RD:
            begin
                state_next = ST_DEL_WR;
            end

            ST_DEL_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                idx_next = idx_reg + PW'(1);
                if (idx_ext + IW'(2) < IW'(count_reg))
                begin
                    state_next = ST_DEL_RD;
                end
                else
                begin
                    count_next     = count_reg - CW'(1);
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    has_item_next  = 1'b0;
                    item_next      = '0;
                    length_next    = LENGTH_W'(count_reg - CW'(1));
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_DUMP_RD:
            begin
                state_next = ST_DUMP_OUT;
            end

            ST_DUMP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    has_item_next  = 1'b1;
                    item_next      = rd_data_reg;
                    length_next    = LENGTH_W'(count_reg);
                    last_next      = (idx_ext + IW'(1) == IW'(count_reg));
                    if (idx_ext + IW'(1) == IW'(count_reg))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + PW'(1);
                        state_next = ST_DUMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        has_item_reg <= has_item_next;
        item_reg     <= item_next;
        length_reg   <= length_next;
        last_reg     <= last_next;
    end

    // Element memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[phys_addr];
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {length_reg, item_reg};
    assign m_axis_tuser  = {has_item_reg, status_reg};
    assign m_axis_tlast  = last_reg;

    // The list never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    // A dumped element always carries an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && has_item_reg) |-> (status_reg == STATUS_OK))
        else $error("dumped element with error status");

    // No result is pending while elements are being shifted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEL_RD || state_reg == ST_DEL_WR) |-> !out_valid_reg)
        else $error("result pending during delete shift");

    // A successful push grows the list by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !full &&
         (in_mode == MODE_PUSH_FRONT || in_mode == MODE_PUSH_BACK))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow the list");

    // The head pointer stays put during a delete or dump sequence; it moves only on a push to the front.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(head_reg))
        else $error("head moved outside a front push");

endmodule
